// ----- sv/ppmp_pkg.sv -----
// Shared types, codes and constants for the P6 stream parser.
package ppmp_pkg;

  // Widths of the header values and the pixel count.
  localparam int unsigned DIM_W   = 17;
  localparam int unsigned DIM3_W  = 19;
  localparam int unsigned ACC_W   = 20;
  localparam int unsigned PROD_W  = DIM3_W + DIM_W;
  localparam int unsigned COUNT_W = 35;

  // Characters and limits of the header syntax.
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [ACC_W-1:0] NUM_LIMIT  = ACC_W'(100000);
  localparam logic [DIM_W-1:0] MAXVAL_REQ = DIM_W'(255);

  // Result kinds.
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_MAGIC  = 3'd0;
  localparam logic [2:0] ERR_HEADER = 3'd1;
  localparam logic [2:0] ERR_MAXVAL = 3'd2;
  localparam logic [2:0] ERR_ZERO   = 3'd3;
  localparam logic [2:0] ERR_SHORT  = 3'd4;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_MAGIC_SKIP,
    PH_MAGIC_SIX,
    PH_W_SKIP,
    PH_W_DIG,
    PH_H_SKIP,
    PH_H_DIG,
    PH_M_SKIP,
    PH_M_DIG,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       pixel_byte;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [2:0]       error_code;
    logic             last_pixel;
  } result_t;

endpackage

// ----- sv/ppmp_in_stage.sv -----
// Input register stage: holds one accepted beat until the parser takes it.
module ppmp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stream_byte,
  input  logic       end_of_file,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_byte,
  output logic       item_eof
);

  // A new beat may enter when the stage is empty or is being emptied.
  assign in_ready = !item_valid || take;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_byte <= stream_byte;
      item_eof  <= end_of_file;
    end
  end

endmodule

// ----- sv/ppmp_parse.sv -----
// Header parser and pixel counter: one step per input beat.
module ppmp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          item_byte,
  input  logic                item_eof,
  output logic                res_valid,
  output ppmp_pkg::result_t   res
);

  ppmp_pkg::phase_t              phase, phase_next;
  logic                          in_comment, in_comment_next;
  logic [ppmp_pkg::DIM_W-1:0]    number_value, number_value_next;
  logic [ppmp_pkg::DIM_W-1:0]    width_seen, width_seen_next;
  logic [ppmp_pkg::DIM_W-1:0]    height_seen, height_seen_next;
  logic [ppmp_pkg::DIM3_W-1:0]   width_x3, width_x3_next;
  logic [ppmp_pkg::PROD_W-1:0]   product;
  logic [ppmp_pkg::COUNT_W-1:0]  bytes_left, bytes_left_next;
  logic                          is_blank, is_digit;
  logic [ppmp_pkg::DIM_W-1:0]    digit;
  logic [ppmp_pkg::ACC_W-1:0]    acc;

  // Character classes and the next decimal accumulation.
  always_comb begin
    is_blank = item_byte inside {ppmp_pkg::CHAR_SPACE, ppmp_pkg::CHAR_TAB,
                                 ppmp_pkg::CHAR_LF, ppmp_pkg::CHAR_CR};
    is_digit = item_byte inside {[ppmp_pkg::CHAR_ZERO:ppmp_pkg::CHAR_NINE]};
    digit    = ppmp_pkg::DIM_W'(item_byte[3:0]);
    acc      = {number_value, 3'b000} + {2'b00, number_value, 1'b0}
               + ppmp_pkg::ACC_W'(item_byte[3:0]);
  end

  // Pixel count, three bytes per pixel. The width has settled long before,
  // and the height is stored at least two beats before the header closes,
  // so this registered product is always current when it is loaded.
  always_ff @(posedge clk) begin
    product <= width_x3 * height_seen;
  end

  // Next state and result.
  always_comb begin
    phase_next        = phase;
    in_comment_next   = in_comment;
    number_value_next = number_value;
    width_seen_next   = width_seen;
    height_seen_next  = height_seen;
    width_x3_next     = width_x3;
    bytes_left_next   = bytes_left;
    res_valid         = 1'b0;
    res               = '0;

    if (step) begin
      case (phase)
        ppmp_pkg::PH_MAGIC_SKIP, ppmp_pkg::PH_W_SKIP,
        ppmp_pkg::PH_H_SKIP, ppmp_pkg::PH_M_SKIP: begin
          if (item_eof) begin
            res_valid      = 1'b1;
            res.kind       = ppmp_pkg::KIND_ERROR;
            res.error_code = (phase == ppmp_pkg::PH_MAGIC_SKIP) ?
                             ppmp_pkg::ERR_MAGIC : ppmp_pkg::ERR_HEADER;
            phase_next     = ppmp_pkg::PH_DONE;
          end else if (in_comment) begin
            if (item_byte == ppmp_pkg::CHAR_LF) begin
              in_comment_next = 1'b0;
            end
          end else if (item_byte == ppmp_pkg::CHAR_HASH) begin
            in_comment_next = 1'b1;
          end else if (is_blank) begin
            phase_next = phase;
          end else if (phase == ppmp_pkg::PH_MAGIC_SKIP) begin
            if (item_byte == ppmp_pkg::CHAR_P) begin
              phase_next = ppmp_pkg::PH_MAGIC_SIX;
            end else begin
              res_valid      = 1'b1;
              res.kind       = ppmp_pkg::KIND_ERROR;
              res.error_code = ppmp_pkg::ERR_MAGIC;
              phase_next     = ppmp_pkg::PH_DONE;
            end
          end else if (is_digit) begin
            number_value_next = digit;
            case (phase)
              ppmp_pkg::PH_W_SKIP: phase_next = ppmp_pkg::PH_W_DIG;
              ppmp_pkg::PH_H_SKIP: phase_next = ppmp_pkg::PH_H_DIG;
              default:             phase_next = ppmp_pkg::PH_M_DIG;
            endcase
          end else begin
            res_valid      = 1'b1;
            res.kind       = ppmp_pkg::KIND_ERROR;
            res.error_code = ppmp_pkg::ERR_HEADER;
            phase_next     = ppmp_pkg::PH_DONE;
          end
        end

        ppmp_pkg::PH_MAGIC_SIX: begin
          if (item_eof || item_byte != ppmp_pkg::CHAR_SIX) begin
            res_valid      = 1'b1;
            res.kind       = ppmp_pkg::KIND_ERROR;
            res.error_code = ppmp_pkg::ERR_MAGIC;
            phase_next     = ppmp_pkg::PH_DONE;
          end else begin
            phase_next = ppmp_pkg::PH_W_SKIP;
          end
        end

        ppmp_pkg::PH_W_DIG, ppmp_pkg::PH_H_DIG, ppmp_pkg::PH_M_DIG: begin
          if (!item_eof && is_digit) begin
            if (acc > ppmp_pkg::NUM_LIMIT) begin
              res_valid      = 1'b1;
              res.kind       = ppmp_pkg::KIND_ERROR;
              res.error_code = ppmp_pkg::ERR_HEADER;
              phase_next     = ppmp_pkg::PH_DONE;
            end else begin
              number_value_next = acc[ppmp_pkg::DIM_W-1:0];
            end
          end else if (phase == ppmp_pkg::PH_M_DIG) begin
            // Header closes on the byte after the maxval digits.
            res_valid = 1'b1;
            if (number_value != ppmp_pkg::MAXVAL_REQ) begin
              res.kind       = ppmp_pkg::KIND_ERROR;
              res.error_code = ppmp_pkg::ERR_MAXVAL;
              phase_next     = ppmp_pkg::PH_DONE;
            end else if (width_seen == '0 || height_seen == '0) begin
              res.kind       = ppmp_pkg::KIND_ERROR;
              res.error_code = ppmp_pkg::ERR_ZERO;
              phase_next     = ppmp_pkg::PH_DONE;
            end else if (item_eof) begin
              res.kind       = ppmp_pkg::KIND_ERROR;
              res.error_code = ppmp_pkg::ERR_SHORT;
              phase_next     = ppmp_pkg::PH_DONE;
            end else begin
              res.kind         = ppmp_pkg::KIND_HEADER;
              res.image_width  = width_seen;
              res.image_height = height_seen;
              bytes_left_next  = product[ppmp_pkg::COUNT_W-1:0];
              phase_next       = ppmp_pkg::PH_PIXELS;
            end
          end else if (item_eof) begin
            res_valid      = 1'b1;
            res.kind       = ppmp_pkg::KIND_ERROR;
            res.error_code = ppmp_pkg::ERR_HEADER;
            phase_next     = ppmp_pkg::PH_DONE;
          end else if (phase == ppmp_pkg::PH_W_DIG) begin
            width_seen_next = number_value;
            width_x3_next   = {2'b00, number_value} + {1'b0, number_value, 1'b0};
            phase_next      = ppmp_pkg::PH_H_SKIP;
          end else begin
            height_seen_next = number_value;
            phase_next       = ppmp_pkg::PH_M_SKIP;
          end
        end

        ppmp_pkg::PH_PIXELS: begin
          res_valid = 1'b1;
          if (item_eof) begin
            res.kind       = ppmp_pkg::KIND_ERROR;
            res.error_code = ppmp_pkg::ERR_SHORT;
            phase_next     = ppmp_pkg::PH_DONE;
          end else if (bytes_left <= ppmp_pkg::COUNT_W'(1)) begin
            res.kind        = ppmp_pkg::KIND_PIXEL;
            res.pixel_byte  = item_byte;
            res.last_pixel  = 1'b1;
            bytes_left_next = '0;
            phase_next      = ppmp_pkg::PH_DONE;
          end else begin
            res.kind        = ppmp_pkg::KIND_PIXEL;
            res.pixel_byte  = item_byte;
            bytes_left_next = bytes_left - ppmp_pkg::COUNT_W'(1);
          end
        end

        default: begin
          phase_next = ppmp_pkg::PH_DONE;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ppmp_pkg::PH_MAGIC_SKIP;
      in_comment   <= 1'b0;
      number_value <= '0;
      width_seen   <= '0;
      height_seen  <= '0;
      width_x3     <= '0;
      bytes_left   <= '0;
    end else begin
      phase        <= phase_next;
      in_comment   <= in_comment_next;
      number_value <= number_value_next;
      width_seen   <= width_seen_next;
      height_seen  <= height_seen_next;
      width_x3     <= width_x3_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

// ----- sv/ppmp_out_buf.sv -----
// Two-entry output buffer: a result register with a skid register behind it.
module ppmp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ppmp_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output ppmp_pkg::result_t out_data
);

  logic              skid_valid;
  ppmp_pkg::result_t skid_data;

  // Room for one more beat as long as the skid register is empty.
  assign space = !skid_valid;

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- sv/ppm_p6_stream_parser.sv -----
// Top level of the binary PPM (P6) stream parser.
// Takes one file byte per beat (with an end-of-file flag) and returns at
// most one result per beat: a header beat with width and height, then
// width*height*3 pixel beats; a single error beat ends the run early. It
// sustains one byte per clock cycle while the output buffer has room; each
// byte is stepped through the combinational parser between the input
// register and a two-entry output buffer, which registers its result. After
// the last pixel byte or an error the block ignores further input,
// end-of-file included, until reset.
module ppm_p6_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  pixel_byte,
  output logic [16:0] image_width,
  output logic [16:0] image_height,
  output logic [2:0]  error_code,
  output logic        last_pixel
);

  logic              item_valid;
  logic [7:0]        item_byte;
  logic              item_eof;
  logic              take;
  logic              space;
  logic              res_valid;
  ppmp_pkg::result_t res;
  ppmp_pkg::result_t out_data;

  // The parser steps whenever a beat is held and the buffer has room.
  assign take = item_valid && space;

  ppmp_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .end_of_file (end_of_file),
    .take        (take),
    .item_valid  (item_valid),
    .item_byte   (item_byte),
    .item_eof    (item_eof)
  );

  ppmp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .item_byte (item_byte),
    .item_eof  (item_eof),
    .res_valid (res_valid),
    .res       (res)
  );

  ppmp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Result fields.
  assign kind         = out_data.kind;
  assign pixel_byte   = out_data.pixel_byte;
  assign image_width  = out_data.image_width;
  assign image_height = out_data.image_height;
  assign error_code   = out_data.error_code;
  assign last_pixel   = out_data.last_pixel;

endmodule

// ----- sv/ppmp_checker.sv -----
// Port-level checks for the P6 stream parser, bound to its top level.
module ppmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  stream_byte,
  input logic        end_of_file,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  pixel_byte,
  input logic [16:0] image_width,
  input logic [16:0] image_height,
  input logic [2:0]  error_code,
  input logic        last_pixel
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // An error or the final pixel is the last beat until reset.
  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (kind == ppmp_pkg::KIND_ERROR || last_pixel)
    |=> !out_valid)
    else $error("result beat after the final one");

  // The last-pixel flag only rides on a pixel beat, with no header fields.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_pixel |->
    kind == ppmp_pkg::KIND_PIXEL && image_width == '0 && image_height == '0)
    else $error("last-pixel flag on a non-pixel beat");

  // A header beat never reports a zero size or an error code.
  a_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ppmp_pkg::KIND_HEADER |->
    image_width != '0 && image_height != '0 && error_code == '0)
    else $error("malformed header beat");

endmodule

bind ppm_p6_stream_parser ppmp_checker u_ppmp_checker (.*);

// ----- bench/tb_ppm_p6_stream_parser.sv -----
// Self-checking testbench for the P6 stream parser: one header and image per run.
module tb_ppm_p6_stream_parser;

  // Image size carried by the header rows below.
  localparam int unsigned IMG_W = 20;
  localparam int unsigned IMG_H = 30;
  localparam int unsigned IMG_BYTES = IMG_W * IMG_H * 3;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 16;

  // One row of the header table; want is used only where typed is set.
  typedef struct packed {
    logic [7:0]        data;
    logic              eof_flag;
    logic              typed;
    ppmp_pkg::result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  stream_byte = 8'd0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  pixel_byte;
  logic [16:0] image_width;
  logic [16:0] image_height;
  logic [2:0]  error_code;
  logic        last_pixel;

  // Predicted parser state.
  ppmp_pkg::phase_t             parse_phase = ppmp_pkg::PH_MAGIC_SKIP;
  logic                         skipping_comment = 1'b0;
  int unsigned                  digits_value = 0;
  int unsigned                  width_got = 0;
  int unsigned                  height_got = 0;
  logic [ppmp_pkg::COUNT_W-1:0] pixels_left = '0;

  ppmp_pkg::result_t pending_results[$];
  stim_row_t         header_rows[$];
  ppmp_pkg::result_t head_result;
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_run = 0;
  int unsigned stall_mode = 0;
  int unsigned cycle_count = 0;
  bit          cut_short = 1'b0;

  ppm_p6_stream_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .stream_byte  (stream_byte),
    .end_of_file  (end_of_file),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .pixel_byte   (pixel_byte),
    .image_width  (image_width),
    .image_height (image_height),
    .error_code   (error_code),
    .last_pixel   (last_pixel)
  );

  always #5 clk = ~clk;

  function automatic logic is_blank(input logic [7:0] c);
    return c == ppmp_pkg::CHAR_SPACE || c == ppmp_pkg::CHAR_TAB ||
           c == ppmp_pkg::CHAR_LF || c == ppmp_pkg::CHAR_CR;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= ppmp_pkg::CHAR_ZERO && c <= ppmp_pkg::CHAR_NINE;
  endfunction

  // Steps the predicted parser by one input beat; returns 1 when a result follows.
  function automatic logic predict_parse(input logic [7:0] c, input logic eof,
                                         output ppmp_pkg::result_t r);
    int unsigned acc;
    logic        fault;
    logic [2:0]  fault_code;
    logic        got;
    r = '0;
    got = 1'b0;
    fault = 1'b0;
    fault_code = ppmp_pkg::ERR_MAGIC;
    case (parse_phase)
      ppmp_pkg::PH_MAGIC_SKIP, ppmp_pkg::PH_W_SKIP,
      ppmp_pkg::PH_H_SKIP, ppmp_pkg::PH_M_SKIP: begin
        if (eof) begin
          fault = 1'b1;
          fault_code = (parse_phase == ppmp_pkg::PH_MAGIC_SKIP) ?
                       ppmp_pkg::ERR_MAGIC : ppmp_pkg::ERR_HEADER;
        end else if (skipping_comment) begin
          if (c == ppmp_pkg::CHAR_LF) skipping_comment = 1'b0;
        end else if (c == ppmp_pkg::CHAR_HASH) begin
          skipping_comment = 1'b1;
        end else if (!is_blank(c)) begin
          if (parse_phase == ppmp_pkg::PH_MAGIC_SKIP) begin
            if (c != ppmp_pkg::CHAR_P) begin
              fault = 1'b1;
              fault_code = ppmp_pkg::ERR_MAGIC;
            end else begin
              parse_phase = ppmp_pkg::PH_MAGIC_SIX;
            end
          end else if (!is_digit(c)) begin
            fault = 1'b1;
            fault_code = ppmp_pkg::ERR_HEADER;
          end else begin
            digits_value = c - ppmp_pkg::CHAR_ZERO;
            parse_phase = ppmp_pkg::phase_t'(parse_phase + 1);
          end
        end
      end
      ppmp_pkg::PH_MAGIC_SIX: begin
        if (eof || c != ppmp_pkg::CHAR_SIX) begin
          fault = 1'b1;
          fault_code = ppmp_pkg::ERR_MAGIC;
        end else begin
          parse_phase = ppmp_pkg::PH_W_SKIP;
        end
      end
      ppmp_pkg::PH_W_DIG, ppmp_pkg::PH_H_DIG, ppmp_pkg::PH_M_DIG: begin
        if (!eof && is_digit(c)) begin
          acc = digits_value * 10 + (c - ppmp_pkg::CHAR_ZERO);
          if (acc > 100000) begin
            fault = 1'b1;
            fault_code = ppmp_pkg::ERR_HEADER;
          end else begin
            digits_value = acc;
          end
        end else if (parse_phase == ppmp_pkg::PH_M_DIG) begin
          // The maxval has ended, so the header is judged as a whole.
          fault = 1'b1;
          if (digits_value != 255) fault_code = ppmp_pkg::ERR_MAXVAL;
          else if (width_got == 0 || height_got == 0) fault_code = ppmp_pkg::ERR_ZERO;
          else if (eof) fault_code = ppmp_pkg::ERR_SHORT;
          else begin
            fault = 1'b0;
            pixels_left = ppmp_pkg::COUNT_W'(width_got) *
                          ppmp_pkg::COUNT_W'(height_got) * 3;
            parse_phase = ppmp_pkg::PH_PIXELS;
            r.kind = ppmp_pkg::KIND_HEADER;
            r.image_width = ppmp_pkg::DIM_W'(width_got);
            r.image_height = ppmp_pkg::DIM_W'(height_got);
            got = 1'b1;
          end
        end else if (eof) begin
          fault = 1'b1;
          fault_code = ppmp_pkg::ERR_HEADER;
        end else begin
          // The byte that ended the digits is swallowed, whatever it was.
          if (parse_phase == ppmp_pkg::PH_W_DIG) width_got = digits_value;
          else height_got = digits_value;
          parse_phase = ppmp_pkg::phase_t'(parse_phase + 1);
        end
      end
      ppmp_pkg::PH_PIXELS: begin
        if (eof) begin
          fault = 1'b1;
          fault_code = ppmp_pkg::ERR_SHORT;
        end else begin
          r.kind = ppmp_pkg::KIND_PIXEL;
          r.pixel_byte = c;
          got = 1'b1;
          if (pixels_left <= 1) begin
            pixels_left = '0;
            parse_phase = ppmp_pkg::PH_DONE;
            r.last_pixel = 1'b1;
          end else begin
            pixels_left = pixels_left - 1;
          end
        end
      end
      default: parse_phase = ppmp_pkg::PH_DONE;
    endcase
    if (fault) begin
      parse_phase = ppmp_pkg::PH_DONE;
      r.kind = ppmp_pkg::KIND_ERROR;
      r.error_code = fault_code;
      got = 1'b1;
    end
    return got;
  endfunction

  task automatic add_row(input logic [7:0] data, input logic eof_flag = 1'b0,
                         input logic typed = 1'b0,
                         input ppmp_pkg::result_t want = '0);
    stim_row_t row;
    row.data = data;
    row.eof_flag = eof_flag;
    row.typed = typed;
    row.want = want;
    header_rows.push_back(row);
  endtask

  // Presents one beat, holding it until accepted, inside bursts with random gaps.
  task automatic send_beat(input stim_row_t row);
    ppmp_pkg::result_t predicted;
    logic              got;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    stream_byte <= row.data;
    end_of_file <= row.eof_flag;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    beats_in++;
    got = predict_parse(row.data, row.eof_flag, predicted);
    if (row.typed) pending_results.push_back(row.want);
    else if (got) pending_results.push_back(predicted);
  endtask

  task automatic random_beat(input logic [7:0] data, input logic eof_flag);
    stim_row_t row;
    row = '0;
    row.data = data;
    row.eof_flag = eof_flag;
    send_beat(row);
  endtask

  // Holds the sender off until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver readiness follows a pattern of its own, changing mode now and then.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run <= $urandom_range(32, 256);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (cycle_count[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Each result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual kind %0d",
                 $time, kind);
        mismatches++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("kind", head_result.kind, kind);
        check_field("pixel_byte", head_result.pixel_byte, pixel_byte);
        check_field("image_width", head_result.image_width, image_width);
        check_field("image_height", head_result.image_height, image_height);
        check_field("error_code", head_result.error_code, error_code);
        check_field("last_pixel", head_result.last_pixel, last_pixel);
      end
    end
  end

  // The run is abandoned when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL ppm_p6_stream_parser");
      $finish;
    end
  end

  initial begin
    ppmp_pkg::result_t header_want;
    int unsigned       pixel_count;
    header_want = '0;
    header_want.kind = ppmp_pkg::KIND_HEADER;
    header_want.image_width = ppmp_pkg::DIM_W'(IMG_W);
    header_want.image_height = ppmp_pkg::DIM_W'(IMG_H);

    // Header with a leading blank and comment, a leading zero in the width,
    // a '#' swallowed as the width terminator so its text is read as header,
    // a comment before the maxval and a zero byte ending the maxval.
    add_row(ppmp_pkg::CHAR_SPACE);
    add_row(ppmp_pkg::CHAR_HASH);
    add_row(ppmp_pkg::CHAR_P);
    add_row(ppmp_pkg::CHAR_LF);
    add_row(ppmp_pkg::CHAR_P);
    add_row(ppmp_pkg::CHAR_SIX);
    add_row(ppmp_pkg::CHAR_CR);
    add_row(ppmp_pkg::CHAR_ZERO);
    add_row(ppmp_pkg::CHAR_ZERO + 8'd2);
    add_row(ppmp_pkg::CHAR_ZERO);
    add_row(ppmp_pkg::CHAR_HASH);
    add_row(ppmp_pkg::CHAR_TAB);
    add_row(ppmp_pkg::CHAR_ZERO + 8'd3);
    add_row(ppmp_pkg::CHAR_ZERO);
    add_row(ppmp_pkg::CHAR_LF);
    add_row(ppmp_pkg::CHAR_HASH);
    add_row(8'hFF);
    add_row(ppmp_pkg::CHAR_LF);
    add_row(ppmp_pkg::CHAR_ZERO + 8'd2);
    add_row(ppmp_pkg::CHAR_ZERO + 8'd5);
    add_row(ppmp_pkg::CHAR_ZERO + 8'd5);
    add_row(8'h00, 1'b0, 1'b1, header_want);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (header_rows[i]) send_beat(header_rows[i]);
    drain_results();

    // Pixel data with random content; some runs cut the image short near its end.
    cut_short = ($urandom_range(0, 3) == 0);
    pixel_count = cut_short ? $urandom_range(IMG_BYTES - 40, IMG_BYTES - 1) : IMG_BYTES;
    for (int unsigned n = 0; n < pixel_count; n++) begin
      random_beat(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 399) == 0) drain_results();
    end
    if (cut_short) begin
      random_beat(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      // Trailing bytes and end-of-file after the image must be ignored.
      repeat ($urandom_range(5, 20))
        random_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      random_beat(8'($urandom_range(0, 255)), 1'b1);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered a %0dx%0d header with blanks, comments and a swallowed '#',",
             IMG_W, IMG_H);
    $display("then %0s; %0d beats in, %0d result beats out.",
             cut_short ? "an image cut short by end of file" :
                         "a complete image followed by ignored bytes",
             beats_in, beats_out);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS ppm_p6_stream_parser");
    end else begin
      $display("FAIL ppm_p6_stream_parser");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ppmp_pkg.sv
sv/ppmp_in_stage.sv
sv/ppmp_parse.sv
sv/ppmp_out_buf.sv
sv/ppm_p6_stream_parser.sv
sv/ppmp_checker.sv
bench/tb_ppm_p6_stream_parser.sv
